### rtl/cgps_pkg.sv
// Shared types, constants and helpers for the conic gradient pixel shader.
// No dependencies; included by every module of the block via wildcard import.
`default_nettype none

package cgps_pkg;

	// Angle, brightness and hue constants.
	localparam int ANGLE_QUAD   = 90;
	localparam int VAL_MAX      = 255;
	localparam int SECTOR       = 60;
	localparam int HUE_RANGE    = 360;
	localparam int SAT_RESET    = 200;
	localparam int CENTER_RESET = 120;
	localparam int CENTER_W     = 10;

	// Field widths.
	localparam int PHASE_W = 9;
	localparam int HUE_W   = 9;
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 16;

	// Angle divider: numerator n*90 with n <= 254, divisor below 255,
	// quotient in 0..90.
	localparam int NUM_W = 15;
	localparam int DEN_W = 8;
	localparam int QUO_W = 7;

	// Pipeline depth of the HSV to RGB565 converter.
	localparam int HSV_STAGES = 5;

	// Configuration register indexes.
	localparam int REG_INDEX_W = 2;
	localparam logic [REG_INDEX_W-1:0] REG_CENTER_X   = 2'd0;
	localparam logic [REG_INDEX_W-1:0] REG_CENTER_Y   = 2'd1;
	localparam logic [REG_INDEX_W-1:0] REG_SATURATION = 2'd2;

	// Per-item data that rides alongside the angle divider.
	typedef struct packed {
		logic [HUE_W-1:0]   base;
		logic [PHASE_W-1:0] phase;
		logic [CHAN_W-1:0]  val;
	} side_t;

	// Hue sector, one per 60 degrees.
	typedef enum logic [2:0] {
		SEC_RED_YEL  = 3'd0,
		SEC_YEL_GRN  = 3'd1,
		SEC_GRN_CYN  = 3'd2,
		SEC_CYN_BLU  = 3'd3,
		SEC_BLU_MAG  = 3'd4,
		SEC_MAG_RED  = 3'd5
	} sector_t;

	// Exact floor(x / 255) for any x up to 255 * 255, the largest product of
	// two channel values.
	function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = 17'(x) + 17'd1 + 17'(x[15:8]);
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

### rtl/cgps_div.sv
// Pipelined restoring divider for the gradient angle, one quotient bit per stage.
// Depends on cgps_pkg for widths and the side data struct.
`default_nettype none

module cgps_div (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   valid,
	input  wire logic [cgps_pkg::NUM_W-1:0] num,
	input  wire logic [cgps_pkg::DEN_W-1:0] den,
	input  cgps_pkg::side_t             side,
	output logic                        done,
	output logic [cgps_pkg::QUO_W-1:0]  quo,
	output cgps_pkg::side_t             side_out
);
	import cgps_pkg::*;

	// Element i holds the item after i quotient bits have been decided.
	logic             vld_s  [QUO_W+1];
	logic [NUM_W-1:0] rem_s  [QUO_W];
	logic [DEN_W-1:0] den_s  [QUO_W];
	logic [QUO_W-1:0] quo_s  [QUO_W+1];
	side_t            side_s [QUO_W+1];

	assign vld_s[0]  = valid;
	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign quo_s[0]  = '0;
	assign side_s[0] = side;

	for (genvar i = 0; i < QUO_W; i++) begin : g_step
		localparam int SH = QUO_W - 1 - i;
		logic [NUM_W-1:0] dsh;
		logic             ge;

		assign dsh = NUM_W'(den_s[i]) << SH;
		assign ge  = rem_s[i] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			quo_s[i+1]  <= {quo_s[i][QUO_W-2:0], ge};
			side_s[i+1] <= side_s[i];
		end

		if (i < QUO_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[i+1] <= ge ? rem_s[i] - dsh : rem_s[i];
				den_s[i+1] <= den_s[i];
			end
		end
	end

	assign done     = vld_s[QUO_W];
	assign quo      = quo_s[QUO_W];
	assign side_out = side_s[QUO_W];

endmodule

`default_nettype wire

### rtl/cgps_hsv.sv
// Five-stage pipelined integer HSV to RGB565 converter.
// Depends on cgps_pkg for the sector type, constants and div255.
`default_nettype none

module cgps_hsv (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      valid,
	input  wire logic [cgps_pkg::HUE_W-1:0]  hue,
	input  wire logic [cgps_pkg::CHAN_W-1:0] val,
	input  wire logic [cgps_pkg::CHAN_W-1:0] sat,
	output logic                           done,
	output logic [cgps_pkg::COLOR_W-1:0]   color
);
	import cgps_pkg::*;

	localparam logic [CHAN_W-1:0] FULL = CHAN_W'(VAL_MAX);

	// Stage 1: sector and fractional position f = (h mod 60) * 255 / 60.
	logic              valid_h1;
	sector_t           sec_h1;
	logic [CHAN_W-1:0] f_h1;
	logic [CHAN_W-1:0] val_h1;

	sector_t          sec_c;
	logic [HUE_W-1:0] off_c;
	logic [HUE_W-1:0] rem_c;
	logic [11:0]      f17_c;

	always_comb begin
		priority if (hue >= HUE_W'(5 * SECTOR)) begin
			sec_c = SEC_MAG_RED;
			off_c = HUE_W'(5 * SECTOR);
		end else if (hue >= HUE_W'(4 * SECTOR)) begin
			sec_c = SEC_BLU_MAG;
			off_c = HUE_W'(4 * SECTOR);
		end else if (hue >= HUE_W'(3 * SECTOR)) begin
			sec_c = SEC_CYN_BLU;
			off_c = HUE_W'(3 * SECTOR);
		end else if (hue >= HUE_W'(2 * SECTOR)) begin
			sec_c = SEC_GRN_CYN;
			off_c = HUE_W'(2 * SECTOR);
		end else if (hue >= HUE_W'(SECTOR)) begin
			sec_c = SEC_YEL_GRN;
			off_c = HUE_W'(SECTOR);
		end else begin
			sec_c = SEC_RED_YEL;
			off_c = '0;
		end
		rem_c = hue - off_c;
		// 255/60 reduces to 17/4, so the scale is a multiply by 17 and a shift.
		f17_c = 12'(rem_c) * 12'(VAL_MAX / 15);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_h1 <= 1'b0;
		end else begin
			valid_h1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		sec_h1 <= sec_c;
		f_h1   <= CHAN_W'(f17_c >> 2);
		val_h1 <= val;
	end

	// Stage 2: the three products that depend only on s, f and v.
	logic              valid_h2;
	sector_t           sec_h2;
	logic [CHAN_W-1:0] val_h2;
	logic [15:0]       sf_h2;
	logic [15:0]       sg_h2;
	logic [15:0]       vp_h2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_h2 <= 1'b0;
		end else begin
			valid_h2 <= valid_h1;
		end
	end

	always_ff @(posedge clk) begin
		sec_h2 <= sec_h1;
		val_h2 <= val_h1;
		sf_h2  <= 16'(sat) * 16'(f_h1);
		sg_h2  <= 16'(sat) * 16'(FULL - f_h1);
		vp_h2  <= 16'(val_h1) * 16'(FULL - sat);
	end

	// Stage 3: scale back by 255; p is final here.
	logic              valid_h3;
	sector_t           sec_h3;
	logic [CHAN_W-1:0] val_h3;
	logic [CHAN_W-1:0] qa_h3;
	logic [CHAN_W-1:0] ta_h3;
	logic [CHAN_W-1:0] p_h3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_h3 <= 1'b0;
		end else begin
			valid_h3 <= valid_h2;
		end
	end

	always_ff @(posedge clk) begin
		sec_h3 <= sec_h2;
		val_h3 <= val_h2;
		qa_h3  <= FULL - div255(sf_h2);
		ta_h3  <= FULL - div255(sg_h2);
		p_h3   <= div255(vp_h2);
	end

	// Stage 4: multiply by v for q and t.
	logic              valid_h4;
	sector_t           sec_h4;
	logic [CHAN_W-1:0] val_h4;
	logic [CHAN_W-1:0] p_h4;
	logic [15:0]       vq_h4;
	logic [15:0]       vt_h4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_h4 <= 1'b0;
		end else begin
			valid_h4 <= valid_h3;
		end
	end

	always_ff @(posedge clk) begin
		sec_h4 <= sec_h3;
		val_h4 <= val_h3;
		p_h4   <= p_h3;
		vq_h4  <= 16'(val_h3) * 16'(qa_h3);
		vt_h4  <= 16'(val_h3) * 16'(ta_h3);
	end

	// Stage 5: final scale, channel selection by sector and RGB565 packing.
	logic              valid_h5;
	logic [COLOR_W-1:0] color_h5;

	logic [CHAN_W-1:0] q_c;
	logic [CHAN_W-1:0] t_c;
	logic [CHAN_W-1:0] r_c;
	logic [CHAN_W-1:0] g_c;
	logic [CHAN_W-1:0] b_c;

	always_comb begin
		q_c = div255(vq_h4);
		t_c = div255(vt_h4);
		unique case (sec_h4)
			SEC_RED_YEL: begin
				r_c = val_h4; g_c = t_c;    b_c = p_h4;
			end
			SEC_YEL_GRN: begin
				r_c = q_c;    g_c = val_h4; b_c = p_h4;
			end
			SEC_GRN_CYN: begin
				r_c = p_h4;   g_c = val_h4; b_c = t_c;
			end
			SEC_CYN_BLU: begin
				r_c = p_h4;   g_c = q_c;    b_c = val_h4;
			end
			SEC_BLU_MAG: begin
				r_c = t_c;    g_c = p_h4;   b_c = val_h4;
			end
			default: begin
				r_c = val_h4; g_c = p_h4;   b_c = q_c;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_h5 <= 1'b0;
		end else begin
			valid_h5 <= valid_h4;
		end
	end

	always_ff @(posedge clk) begin
		color_h5 <= {r_c[7:3], g_c[7:2], b_c[7:3]};
	end

	assign done  = valid_h5;
	assign color = color_h5;

endmodule

`default_nettype wire

### rtl/conic_gradient_pixel_shader.sv
// Top level of the conic gradient pixel shader: front end, angle divider, hue wrap.
// Depends on cgps_pkg, cgps_div and cgps_hsv.
`default_nettype none

// Usage
// The block shades one pixel per item. An item (pixel_x, pixel_y, phase) is
// accepted at each rising edge where start is high and busy is low. Busy is
// always low: the block is a fully pipelined datapath and accepts an item in
// every cycle, so the sustained rate is one pixel per clock.
// Each item produces exactly one result. Its RGB565 color is on color with done
// high for one cycle once the item has passed every register stage; it is
// taken at the edge that ends that cycle. There are 17 register stages, the
// first loaded at the accepting edge: four front-end stages (offset, absolute
// value, Manhattan sum and quadrant, multiply by 90), seven divider stages that
// each decide one bit of the angle, one stage for the hue wrap and five stages
// of HSV to RGB565 conversion.
// The receiver has no way to stall the block; results must be taken as they
// appear. Items are shaded in order and results keep that order.
// The configuration port writes center_x, center_y and saturation through
// wr_en, wr_index and wr_data; unknown indexes are ignored. Registers should
// only change while no item is in flight.
// Reset (arst_n low) clears all valid bits, so no result is produced for items
// in flight, and returns the center to (120, 120) and saturation to 200.
// Pixels at Manhattan distance 255 or more from the center come out black.

module conic_gradient_pixel_shader #(
	parameter int COORD_BITS = 10,
	localparam int WR_W = (COORD_BITS > 8) ? COORD_BITS : 8
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [COORD_BITS-1:0]               pixel_x,
	input  wire logic [COORD_BITS-1:0]               pixel_y,
	input  wire logic [cgps_pkg::PHASE_W-1:0]        phase,
	output logic                                     done,
	output logic [cgps_pkg::COLOR_W-1:0]             color,
	input  wire logic                                wr_en,
	input  wire logic [cgps_pkg::REG_INDEX_W-1:0]    wr_index,
	input  wire logic [WR_W-1:0]                     wr_data
);
	import cgps_pkg::*;

	localparam int LATENCY = 4 + QUO_W + 1 + HSV_STAGES;
	localparam logic [COORD_BITS-1:0] CENTER_MASK =
		COORD_BITS'((1 << CENTER_W) - 1);

	// Configuration registers.
	logic [COORD_BITS-1:0] center_x_q;
	logic [COORD_BITS-1:0] center_y_q;
	logic [CHAN_W-1:0]     saturation_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= COORD_BITS'(CENTER_RESET);
			center_y_q   <= COORD_BITS'(CENTER_RESET);
			saturation_q <= CHAN_W'(SAT_RESET);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CENTER_X:   center_x_q   <= wr_data[COORD_BITS-1:0] & CENTER_MASK;
				REG_CENTER_Y:   center_y_q   <= wr_data[COORD_BITS-1:0] & CENTER_MASK;
				REG_SATURATION: saturation_q <= wr_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline never stalls, so an item is taken whenever start is high.
	assign busy = 1'b0;

	// Stage 1: signed offsets from the center.
	logic                         valid_s1;
	logic signed [COORD_BITS:0]   dx_s1;
	logic signed [COORD_BITS:0]   dy_s1;
	logic [PHASE_W-1:0]           phase_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1    <= signed'({1'b0, pixel_x}) - signed'({1'b0, center_x_q});
		dy_s1    <= signed'({1'b0, pixel_y}) - signed'({1'b0, center_y_q});
		phase_s1 <= phase;
	end

	// Stage 2: magnitudes and the sign bits that select the quadrant.
	logic                  valid_s2;
	logic [COORD_BITS-1:0] ax_s2;
	logic [COORD_BITS-1:0] ay_s2;
	logic                  sx_s2;
	logic                  sy_s2;
	logic [PHASE_W-1:0]    phase_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s2    <= dx_s1[COORD_BITS] ? COORD_BITS'(-dx_s1) : COORD_BITS'(dx_s1);
		ay_s2    <= dy_s1[COORD_BITS] ? COORD_BITS'(-dy_s1) : COORD_BITS'(dy_s1);
		sx_s2    <= dx_s1[COORD_BITS];
		sy_s2    <= dy_s1[COORD_BITS];
		phase_s2 <= phase_s1;
	end

	// Stage 3: Manhattan distance, brightness, quadrant base and divider operands.
	// Beyond distance 254 the brightness is zero and the color is black whatever
	// the hue, so the divider only ever sees 8-bit operands.
	logic               valid_s3;
	logic [CHAN_W-1:0]  n_s3;
	logic [DEN_W-1:0]   den_s3;
	side_t              side_s3;

	logic [COORD_BITS:0] sum_c;
	logic [15:0]         sum_w;
	logic                big_c;
	logic [15:0]         ax_w;
	logic [15:0]         ay_w;
	logic [15:0]         n_w;
	logic [HUE_W-1:0]    base_c;

	always_comb begin
		sum_c = {1'b0, ax_s2} + {1'b0, ay_s2};
		sum_w = 16'(sum_c);
		big_c = sum_w >= 16'(VAL_MAX);
		ax_w  = 16'(ax_s2);
		ay_w  = 16'(ay_s2);
		unique case ({sx_s2, sy_s2})
			2'b00: begin
				base_c = '0;
				n_w    = ay_w;
			end
			2'b10: begin
				base_c = HUE_W'(ANGLE_QUAD);
				n_w    = ax_w;
			end
			2'b11: begin
				base_c = HUE_W'(2 * ANGLE_QUAD);
				n_w    = ay_w;
			end
			default: begin
				base_c = HUE_W'(3 * ANGLE_QUAD);
				n_w    = ax_w;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		n_s3          <= big_c ? '0 : n_w[CHAN_W-1:0];
		// At the center the numerator is zero; a divisor of one gives angle zero.
		den_s3        <= (big_c || sum_c == '0) ? DEN_W'(1) : sum_w[DEN_W-1:0];
		side_s3.base  <= base_c;
		side_s3.phase <= phase_s2;
		side_s3.val   <= big_c ? '0 : CHAN_W'(VAL_MAX) - sum_w[CHAN_W-1:0];
	end

	// Stage 4: scale the numerator by 90 degrees.
	logic             valid_s4;
	logic [NUM_W-1:0] num_s4;
	logic [DEN_W-1:0] den_s4;
	side_t            side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		num_s4  <= NUM_W'(n_s3) * NUM_W'(ANGLE_QUAD);
		den_s4  <= den_s3;
		side_s4 <= side_s3;
	end

	// Angle within the quadrant, one quotient bit per stage.
	logic             div_valid;
	logic [QUO_W-1:0] div_quo;
	side_t            div_side;

	cgps_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid_s4),
		.num      (num_s4),
		.den      (den_s4),
		.side     (side_s4),
		.done     (div_valid),
		.quo      (div_quo),
		.side_out (div_side)
	);

	// Hue stage: angle plus phase, wrapped into 0..359. The sum stays below
	// three full turns, so at most one of two fixed subtractions applies.
	logic              valid_s12;
	logic [HUE_W-1:0]  hue_s12;
	logic [CHAN_W-1:0] val_s12;

	logic [HUE_W:0]   hsum_c;
	logic [HUE_W-1:0] hue_c;

	always_comb begin
		hsum_c = (HUE_W + 1)'(div_side.base) + (HUE_W + 1)'(div_quo)
			+ (HUE_W + 1)'(div_side.phase);
		priority if (hsum_c >= (HUE_W + 1)'(2 * HUE_RANGE)) begin
			hue_c = HUE_W'(hsum_c - (HUE_W + 1)'(2 * HUE_RANGE));
		end else if (hsum_c >= (HUE_W + 1)'(HUE_RANGE)) begin
			hue_c = HUE_W'(hsum_c - (HUE_W + 1)'(HUE_RANGE));
		end else begin
			hue_c = HUE_W'(hsum_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else begin
			valid_s12 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		hue_s12 <= hue_c;
		val_s12 <= div_side.val;
	end

	// Color conversion with the configured saturation.
	cgps_hsv u_hsv (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s12),
		.hue    (hue_s12),
		.val    (val_s12),
		.sat    (saturation_q),
		.done   (done),
		.color  (color)
	);

`ifndef ASSERT_OFF
	// Every accepted item yields exactly one result after the fixed latency.
	a_latency_out : assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("accepted item did not produce a result on time");

	a_latency_in : assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching accepted item");

	// The angle inside one quadrant never exceeds a quarter turn.
	a_quo_range : assert property (@(posedge clk) disable iff (!arst_n)
		div_valid |-> div_quo <= QUO_W'(ANGLE_QUAD))
		else $error("divider quotient above 90");

	// Zero brightness must come out black.
	a_black : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && side_s3.val == '0 |-> ##(LATENCY - 3) (done && color == '0))
		else $error("zero brightness pixel is not black");
`endif

endmodule

`default_nettype wire
